@@ rtl/b64d_pkg.sv @@
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;
    localparam int ACC_W    = 16;
    localparam int PHASE_W  = 2;

    // Character codes of the alphabet edges and the extra symbols
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7a;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5f;

    localparam logic [SEXTET_W-1:0] SX_62 = 6'h3e;
    localparam logic [SEXTET_W-1:0] SX_63 = 6'h3f;

    // Phase codes within a group of four sextets
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd1;
    localparam logic [PHASE_W-1:0] PH_THIRD  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_FOURTH = 2'd3;

    // One mapped character between the input stage and the packer
    typedef struct packed {
        logic                first;
        logic                hit;
        logic [SEXTET_W-1:0] sextet;
    } sym_t;

    // Character to sextet; hit is low for skipped characters
    function automatic sym_t map_char(input logic [CHAR_W-1:0] ch, input logic first);
        sym_t s;
        logic [CHAR_W-1:0] d;
        s.first  = first;
        s.hit    = 1'b1;
        s.sextet = '0;
        d        = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            d        = ch - CH_UPPER_A;
            s.sextet = d[SEXTET_W-1:0];
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            d        = ch - CH_LOWER_A + 8'd26;
            s.sextet = d[SEXTET_W-1:0];
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            d        = ch - CH_DIGIT_0 + 8'd52;
            s.sextet = d[SEXTET_W-1:0];
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            s.sextet = SX_62;
        end else if (ch == CH_SLASH || ch == CH_UNDER) begin
            s.sextet = SX_63;
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

    // Left shift applied to the sextet in each phase
    function automatic logic [3:0] shift_of(input logic [PHASE_W-1:0] ph);
        logic [3:0] sh;
        case (ph)
            PH_FIRST:  sh = 4'd10;
            PH_SECOND: sh = 4'd4;
            PH_THIRD:  sh = 4'd6;
            PH_FOURTH: sh = 4'd8;
            default:   sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

`default_nettype wire

@@ rtl/b64d_in_stage.sv @@
`default_nettype none

module b64d_in_stage (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [b64d_pkg::CHAR_W-1:0]      s_tdata,
    input  wire                              s_tuser,
    input  wire                              take,
    output logic                             sym_valid,
    output b64d_pkg::sym_t                   sym
);
    import b64d_pkg::*;

    logic s1_valid_reg, s1_valid_next;
    sym_t sym_reg;

    // Stage is free when empty or when the packer takes its request
    assign s_tready  = !s1_valid_reg || take;
    assign sym_valid = s1_valid_reg;
    assign sym       = sym_reg;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_tready) begin
            s1_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Lookup is done before the register
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            sym_reg <= map_char(s_tdata, s_tuser);
        end
    end

endmodule

`default_nettype wire

@@ rtl/b64d_pack.sv @@
`default_nettype none

module b64d_pack (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              sym_valid,
    input  b64d_pkg::sym_t                   sym,
    output logic                             take,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [b64d_pkg::CHAR_W-1:0]      m_tdata
);
    import b64d_pkg::*;

    logic [ACC_W-1:0]   held_reg, held_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_byte_reg, out_byte_next;

    logic               out_free;
    logic [ACC_W-1:0]   held_eff, acc;
    logic [PHASE_W-1:0] phase_eff;
    logic               emit;

    assign out_free = !out_valid_reg || m_tready;
    assign take     = sym_valid && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

    // Start of string clears the held bits and phase first
    assign held_eff  = sym.first ? '0 : held_reg;
    assign phase_eff = sym.first ? PH_FIRST : phase_reg;
    assign acc  = held_eff | (ACC_W'(sym.sextet) << shift_of(phase_eff));
    assign emit = sym.hit && (phase_eff != PH_FIRST);

    // Accumulator and phase update
    always_comb begin
        held_next  = held_reg;
        phase_next = phase_reg;
        if (take) begin
            if (sym.hit) begin
                held_next  = emit ? {acc[CHAR_W-1:0], {CHAR_W{1'b0}}} : acc;
                phase_next = phase_eff + PHASE_W'(1);
            end else begin
                held_next  = held_eff;
                phase_next = phase_eff;
            end
        end
    end

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        if (take && emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = acc[ACC_W-1:CHAR_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
        end else begin
            held_reg      <= held_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
    end

    // Held bits sit only in the top bits the phase allows
    a_ph_first: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FIRST |-> held_reg == '0)
        else $error("held bits not empty at group start");
    a_ph_second: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SECOND |-> held_reg[9:0] == '0)
        else $error("stray low bits in second phase");
    a_ph_third: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_THIRD |-> held_reg[11:0] == '0)
        else $error("stray low bits in third phase");
    a_ph_fourth: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_FOURTH |-> held_reg[13:0] == '0)
        else $error("stray low bits in fourth phase");
    a_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && !emit) |=> !out_valid_reg)
        else $error("result shown without a completed byte");

endmodule

`default_nettype wire

@@ rtl/base64_stream_decoder.sv @@
// A finished byte passes the input register and the result register to m_tdata.
// Throughput: one character per cycle with m_tready high; the input register and
// result register let a new request enter while a finished byte waits to be taken.
// Skipped characters and first sextets of a group give no output byte.
// Reset (aresetn low, synchronous): both stages empty, held bits and phase cleared.
`default_nettype none

module base64_stream_decoder (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [b64d_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] char_in
    input  wire                              s_tuser,   // [0] first
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [b64d_pkg::CHAR_W-1:0]      m_tdata    // [7:0] byte_out
);
    import b64d_pkg::*;

    logic sym_valid;
    logic take;
    sym_t sym;

    b64d_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .take      (take),
        .sym_valid (sym_valid),
        .sym       (sym)
    );

    b64d_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sym_valid (sym_valid),
        .sym       (sym),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import b64d_pkg::*;

    // Directed stimulus row: typed rows carry their expected byte,
    // the others are predicted
    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       typed;
        logic       has_byte;
        logic [7:0] byte_val;
    } dir_row_t;

    typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_e;

    logic       aclk;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_in
    logic       s_tuser  = 1'b0;    // [0] first
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] byte_out

    // Typed expectation that travels with the request on the bus
    logic       row_typed    = 1'b0;
    logic       row_has_byte = 1'b0;
    logic [7:0] row_byte     = 8'h00;

    // Decoder model state
    logic [15:0]        dec_bits;
    logic [PHASE_W-1:0] dec_phase;

    logic [7:0] byte_q[$];
    int         err_count  = 0;
    int         burst_left = 0;
    bit         hold_req   = 1'b0;

    dir_row_t dir_tab [25];

    base64_stream_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                   input logic [7:0] want_v);
        $display("mismatch at %0t: %s got %02h want %02h", $realtime, what, got_v, want_v);
        err_count++;
    endtask

    // Character to sextet; returns 0 for characters outside the alphabet
    function automatic bit char_sextet(input logic [7:0] ch, output logic [5:0] sx);
        logic [7:0] d;
        d  = 8'h00;
        sx = 6'h00;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) d = ch - CH_UPPER_A;
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) d = ch - CH_LOWER_A + 8'd26;
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) d = ch - CH_DIGIT_0 + 8'd52;
        else if (ch == CH_PLUS || ch == CH_MINUS) d = 8'd62;
        else if (ch == CH_SLASH || ch == CH_UNDER) d = 8'd63;
        else return 1'b0;
        sx = d[5:0];
        return 1'b1;
    endfunction

    // Advance the decoder model by one character; flags a finished byte
    function automatic void decode_char(input logic [7:0] ch, input logic first,
                                        output bit got, output logic [7:0] out_byte);
        logic [5:0]  sx;
        logic [4:0]  sh;
        logic [23:0] acc;
        got      = 1'b0;
        out_byte = 8'h00;
        if (first) begin
            dec_bits  = 16'h0000;
            dec_phase = PH_FIRST;
        end
        if (!char_sextet(ch, sx)) return;
        case (dec_phase)
            PH_FIRST:  sh = 5'd10;
            PH_SECOND: sh = 5'd4;
            PH_THIRD:  sh = 5'd6;
            default:   sh = 5'd8;
        endcase
        acc = {8'h00, dec_bits} | ({18'h0, sx} << sh);
        if (dec_phase != PH_FIRST) begin
            got      = 1'b1;
            out_byte = acc[15:8];
            acc      = {8'h00, acc[7:0], 8'h00};
        end
        dec_bits  = acc[15:0];
        dec_phase = dec_phase + 1'b1;
    endfunction

    function automatic logic [7:0] rand_alpha_char();
        int idx;
        idx = $urandom_range(0, 63);
        if (idx < 26) return 8'(CH_UPPER_A + idx);
        if (idx < 52) return 8'(CH_LOWER_A + (idx - 26));
        if (idx < 62) return 8'(CH_DIGIT_0 + (idx - 52));
        if (idx == 62) return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        return $urandom_range(0, 1) ? CH_SLASH : CH_UNDER;
    endfunction

    // Offer one request in bursts with random gaps; returns at the
    // falling edge after it was taken
    task automatic send_char(input logic [7:0] ch, input logic first, input logic typed,
                             input logic has_byte, input logic [7:0] byte_val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid     = 1'b1;
        s_tdata      = ch;
        s_tuser      = first;
        row_typed    = typed;
        row_has_byte = has_byte;
        row_byte     = byte_val;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (byte_q.size() != 0) @(negedge aclk);
    endtask

    // Scoreboard: check taken bytes, then predict for the taken request
    always @(posedge aclk) begin : mon
        bit         got_b;
        logic [7:0] pb;
        logic [7:0] want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (byte_q.size() == 0) begin
                    report_mismatch("unexpected byte", m_tdata, 8'h00);
                end else begin
                    want = byte_q.pop_front();
                    if (m_tdata !== want) report_mismatch("byte_out", m_tdata, want);
                end
            end
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tuser, got_b, pb);
                if (row_typed) begin
                    got_b = row_has_byte;
                    pb    = row_byte;
                end
                if (got_b) byte_q.push_back(pb);
            end
        end
    end

    // Receiver: switches between stall patterns, plus long hold-offs on request
    initial begin : rx
        rx_mode_e mode;
        int       mode_left;
        int       hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   m_tready = 1'b1;
                    RX_HALF:   m_tready = 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
                    default:   m_tready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin : stim
        int         sym_count;
        int         str_left;
        logic       f;
        logic [7:0] ch;
        bit         hold_done;
        bit         pause_done;

        dec_bits  = 16'h0000;
        dec_phase = PH_FIRST;

        // "TWFu" -> "Man", all-63 and all-62 groups with skips between,
        // restarts that drop trailing bits, edges of the byte range
        dir_tab = '{
            '{"T",   1'b1, 1'b1, 1'b0, 8'h00},
            '{"W",   1'b0, 1'b1, 1'b1, 8'h4d},
            '{"F",   1'b0, 1'b1, 1'b1, 8'h61},
            '{"u",   1'b0, 1'b1, 1'b1, 8'h6e},
            '{"=",   1'b0, 1'b1, 1'b0, 8'h00},
            '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
            '{"/",   1'b1, 1'b1, 1'b0, 8'h00},
            '{"_",   1'b0, 1'b1, 1'b1, 8'hff},
            '{"/",   1'b0, 1'b1, 1'b1, 8'hff},
            '{"_",   1'b0, 1'b1, 1'b1, 8'hff},
            '{"+",   1'b1, 1'b1, 1'b0, 8'h00},
            '{"-",   1'b0, 1'b1, 1'b1, 8'hfb},
            '{8'h20, 1'b0, 1'b1, 1'b0, 8'h00},
            '{8'h80, 1'b0, 1'b1, 1'b0, 8'h00},
            '{"+",   1'b0, 1'b1, 1'b1, 8'hef},
            '{8'hff, 1'b0, 1'b1, 1'b0, 8'h00},
            '{"-",   1'b0, 1'b1, 1'b1, 8'hbe},
            '{"A",   1'b1, 1'b1, 1'b0, 8'h00},
            '{"z",   1'b0, 1'b0, 1'b0, 8'h00},
            '{8'h1f, 1'b0, 1'b1, 1'b0, 8'h00},
            '{"9",   1'b0, 1'b0, 1'b0, 8'h00},
            '{"Z",   1'b1, 1'b1, 1'b0, 8'h00},
            '{8'h40, 1'b1, 1'b1, 1'b0, 8'h00},
            '{"a",   1'b0, 1'b1, 1'b0, 8'h00},
            '{"0",   1'b0, 1'b0, 1'b0, 8'h00}
        };

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i])
            send_char(dir_tab[i].ch, dir_tab[i].first, dir_tab[i].typed,
                      dir_tab[i].has_byte, dir_tab[i].byte_val);
        wait_drained();

        // Random strings: mostly alphabet characters, some noise and restarts
        sym_count  = 0;
        str_left   = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (sym_count < 2000) begin
            if (str_left == 0) begin
                str_left = $urandom_range(1, 48);
                f        = 1'b1;
            end else begin
                f = ($urandom_range(0, 49) == 0);
            end
            str_left--;
            if ($urandom_range(0, 99) < 85) ch = rand_alpha_char();
            else ch = 8'($urandom_range(0, 255));
            sym_count++;
            send_char(ch, f, 1'b0, 1'b0, 8'h00);
            if (!hold_done && sym_count >= 300) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && sym_count >= 1200) begin
                wait_drained();
                pause_done = 1'b1;
            end
        end
        s_tvalid = 1'b0;

        while (byte_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
